/* design/wmft_pkg.sv */
// Shared types and constants for the window maximum frequency tracker.
`timescale 1ns / 1ps
`default_nettype none

package wmft_pkg;

  // Default widths of the value space and of the occurrence counts
  localparam int DefValueBits = 16;
  localparam int DefCountBits = 12;

  // Width of the reported maximum
  localparam int MaxOutBits = 12;

  // Opcodes of an input word
  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // Fault codes of a result word
  localparam logic [1:0] FAULT_OK        = 2'd0;
  localparam logic [1:0] FAULT_ABSENT    = 2'd1;
  localparam logic [1:0] FAULT_SATURATED = 2'd2;

  // Controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_UPDATE,
    ST_BUMP,
    ST_DONE
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic clear;
    logic load;
    logic look;
    logic update;
    logic bump;
    logic emit;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic clear_last;
    logic fault_hit;
  } status_t;

endpackage

`default_nettype wire

/* design/wmft_datapath.sv */
// Datapath: count memories, running maximum and result registers.
`timescale 1ns / 1ps
`default_nettype none

module wmft_datapath #(
  parameter int VALUE_BITS = wmft_pkg::DefValueBits,
  parameter int COUNT_BITS = wmft_pkg::DefCountBits
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire wmft_pkg::cmd_t                   cmd,
  output wmft_pkg::status_t                     status,
  input  wire logic                             opcode,
  input  wire logic [VALUE_BITS-1:0]            value,
  output logic      [wmft_pkg::MaxOutBits-1:0]  max_frequency,
  output logic      [1:0]                       fault
);
  import wmft_pkg::*;

  localparam int NumValues = 2 ** VALUE_BITS;
  localparam int NumCounts = 2 ** COUNT_BITS;
  localparam int TallyBits = VALUE_BITS + 1;
  localparam int ClrBits   = (VALUE_BITS > COUNT_BITS) ? VALUE_BITS : COUNT_BITS;
  localparam int ExtBits   = (COUNT_BITS > MaxOutBits) ? COUNT_BITS : MaxOutBits;

  // Per-value occurrence counts and per-count tallies of values
  logic [COUNT_BITS-1:0] occ_mem [NumValues];
  logic [TallyBits-1:0]  vac_mem [NumCounts];

  logic                  op_q;
  logic [VALUE_BITS-1:0] val_q;
  logic [COUNT_BITS-1:0] occ_rd;
  logic [COUNT_BITS-1:0] cnt_q;
  logic [COUNT_BITS-1:0] nb_q;
  logic [TallyBits-1:0]  vac_a;
  logic [TallyBits-1:0]  vac_b;
  logic [1:0]            fault_q;
  logic [COUNT_BITS-1:0] cur_max;
  logic [ClrBits-1:0]    clr_idx;

  logic [1:0]            fault_c;
  logic [COUNT_BITS-1:0] nb_c;
  logic                  occ_we;
  logic [VALUE_BITS-1:0] occ_wa;
  logic [COUNT_BITS-1:0] occ_wd;
  logic                  vac_we;
  logic [COUNT_BITS-1:0] vac_wa;
  logic [TallyBits-1:0]  vac_wd;
  logic [TallyBits-1:0]  vac_a_dec;
  logic [ExtBits-1:0]    max_ext;

  // Classify the looked-up count and pick the neighbouring count
  always_comb begin
    fault_c = FAULT_OK;
    if (op_q == OP_ADD && occ_rd == {COUNT_BITS{1'b1}}) begin
      fault_c = FAULT_SATURATED;
    end else if (op_q == OP_REMOVE && occ_rd == '0) begin
      fault_c = FAULT_ABSENT;
    end
    nb_c = (op_q == OP_ADD) ? occ_rd + 1'b1 : occ_rd - 1'b1;
  end

  assign status.fault_hit  = (fault_c != FAULT_OK);
  assign status.clear_last = (clr_idx == {ClrBits{1'b1}});

  // Drop the tally of the old count, never below zero
  assign vac_a_dec = (vac_a != '0) ? vac_a - 1'b1 : vac_a;

  // Select the write port sources
  always_comb begin
    occ_we = cmd.clear | cmd.update;
    occ_wa = cmd.clear ? clr_idx[VALUE_BITS-1:0] : val_q;
    occ_wd = cmd.clear ? '0 : nb_q;
    vac_we = 1'b0;
    vac_wa = nb_q;
    vac_wd = vac_b + 1'b1;
    if (cmd.clear) begin
      vac_we = 1'b1;
      vac_wa = clr_idx[COUNT_BITS-1:0];
      vac_wd = '0;
    end else if (cmd.update) begin
      vac_we = (cnt_q != '0);
      vac_wa = cnt_q;
      vac_wd = vac_a_dec;
    end else if (cmd.bump) begin
      vac_we = (nb_q != '0);
    end
  end

  // Occurrence count memory
  always_ff @(posedge clk) begin
    if (occ_we) begin
      occ_mem[occ_wa] <= occ_wd;
    end
    if (cmd.load) begin
      occ_rd <= occ_mem[value];
    end
  end

  // Tally memory, read at the old and the new count
  always_ff @(posedge clk) begin
    if (vac_we) begin
      vac_mem[vac_wa] <= vac_wd;
    end
    if (cmd.look) begin
      vac_a <= vac_mem[occ_rd];
      vac_b <= vac_mem[nb_c];
    end
  end

  // Capture the input word and the looked-up count
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= opcode;
      val_q <= value;
    end
    if (cmd.look) begin
      cnt_q   <= occ_rd;
      nb_q    <= nb_c;
      fault_q <= fault_c;
    end
  end

  // Advance the clearing sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (cmd.clear) begin
      clr_idx <= clr_idx + 1'b1;
    end
  end

  // Track the running maximum
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_max <= '0;
    end else if (cmd.update) begin
      if (op_q == OP_ADD) begin
        if (nb_q > cur_max) begin
          cur_max <= nb_q;
        end
      end else if (cur_max == cnt_q && vac_a_dec == '0) begin
        cur_max <= cur_max - 1'b1;
      end
    end
  end

  assign max_ext = ExtBits'(cur_max);

  // Hold the result word
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      max_frequency <= max_ext[MaxOutBits-1:0];
      fault         <= fault_q;
    end
  end

endmodule

`default_nettype wire

/* design/wmft_ctrl.sv */
// Controller: sequencing of clearing, lookup, update and result hand-off.
`timescale 1ns / 1ps
`default_nettype none

module wmft_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  output logic                    out_valid,
  input  wire logic               out_stall,
  input  wire wmft_pkg::status_t  status,
  output wmft_pkg::cmd_t          cmd
);
  import wmft_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = ~out_valid | ~out_stall;
  assign in_stall = (state != ST_IDLE);

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: begin
        cmd.look   = 1'b1;
        state_next = status.fault_hit ? ST_DONE : ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = ST_BUMP;
      end
      ST_BUMP: begin
        cmd.bump   = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  // Output valid: set on emit, drop when the word is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (~out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

/* design/window_max_frequency_tracker_unit.sv */
// Top level of the window maximum frequency tracker.
//
//  Channel | Direction | Handshake            | Payload
//  --------+-----------+----------------------+----------------------------------
//  in      | input     | in_valid / in_stall  | opcode, value
//  out     | output    | out_valid / out_stall| max_frequency, fault
//
//  A word that updates the counts goes through the look, update, bump and done
//  states from acceptance to result; a faulted word goes from look to done. This
//  follows the dependent read of the count memory, then the tally memory, and
//  two write-backs through the one write port. After reset a clearing sweep
//  over every address zeroes both memories; in_stall stays high throughout.
//  A finished result waits in the output register while the next word is taken.
`timescale 1ns / 1ps
`default_nettype none

module window_max_frequency_tracker_unit #(
  parameter int VALUE_BITS = wmft_pkg::DefValueBits,
  parameter int COUNT_BITS = wmft_pkg::DefCountBits
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic                             opcode,
  input  wire logic [VALUE_BITS-1:0]            value,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic      [wmft_pkg::MaxOutBits-1:0]  max_frequency,
  output logic      [1:0]                       fault
);
  import wmft_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequence each word
  wmft_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Hold the counts and compute the maximum
  wmft_datapath #(
    .VALUE_BITS (VALUE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .opcode        (opcode),
    .value         (value),
    .max_frequency (max_frequency),
    .fault         (fault)
  );

endmodule

`default_nettype wire
